[hw/rtl/tla_pkg.sv]
package tla_pkg;

  localparam int TLA_MAX_TOPIC_LENGTH = 65535;
  localparam logic [15:0] TLA_MAX_DEPTH_RESET = 16'd32;

  // register word indexes
  localparam logic REG_MAX_DEPTH = 1'b0;

  localparam logic [7:0] CH_END = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  // byte classes
  localparam logic [1:0] CLS_BYTE = 2'd0;
  localparam logic [1:0] CLS_SEP = 2'd1;
  localparam logic [1:0] CLS_END = 2'd2;

  // level kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_PLUS = 2'd1;
  localparam logic [1:0] KIND_HASH = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] cls;
  } tok_t;

  typedef struct packed {
    logic [15:0] level_index;
    logic [15:0] level_start;
    logic [31:0] level_hash;
    logic [1:0]  level_kind;
    logic        last;
    logic [15:0] level_count;
    logic [15:0] wildcard_count;
    logic [15:0] multicard_count;
    logic        system_topic;
    logic        too_deep;
    logic [15:0] topic_length;
  } rec_t;

  function automatic logic [15:0] inc_sat16(input logic [15:0] v, input logic [15:0] limit);
    inc_sat16 = (v < limit) ? v + 16'd1 : limit;
  endfunction

endpackage

[hw/rtl/tla_front.sv]
module tla_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    ch,
  output logic          full,
  output logic          tok_valid,
  output tla_pkg::tok_t tok,
  input  logic          tok_take
);
  import tla_pkg::*;

  tok_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  tok_t       tok_in;

  assign full = (count == 2'd2);
  assign tok_valid = (count != 2'd0);
  assign tok = mem[rd_ptr];
  assign wr_en = push && !full;

  always_comb begin
    tok_in.ch = ch;
    if (ch == CH_END) begin
      tok_in.cls = CLS_END;
    end else if (ch == CH_SLASH) begin
      tok_in.cls = CLS_SEP;
    end else begin
      tok_in.cls = CLS_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (tok_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, tok_take};
    end
  end

endmodule

[hw/rtl/tla_back.sv]
module tla_back #(
  parameter int MAX_TOPIC_LENGTH = tla_pkg::TLA_MAX_TOPIC_LENGTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   max_depth,
  input  logic          tok_valid,
  input  tla_pkg::tok_t tok,
  output logic          tok_take,
  output logic          empty,
  input  logic          pop,
  output tla_pkg::rec_t rec
);
  import tla_pkg::*;

  localparam logic [15:0] MaxPos = 16'(MAX_TOPIC_LENGTH);
  localparam logic [15:0] Sat16 = 16'hFFFF;

  logic [31:0] run_hash;
  logic [15:0] position;
  logic [15:0] start_of_level;
  logic [7:0]  first_byte_of_level;
  logic [1:0]  bytes_in_level;
  logic [15:0] levels_seen;
  logic [15:0] plus_levels;
  logic [15:0] hash_levels;
  logic        system_flag;

  rec_t        mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        out_space;
  logic        is_byte;
  logic        rec_wr;
  logic        do_pop;

  logic [31:0] sc;
  logic [31:0] hash_next;
  logic [15:0] pos_inc;
  logic        one_byte;
  logic [15:0] levels_next;
  logic [15:0] plus_next;
  logic [15:0] hash_levels_next;
  logic        system_next;
  rec_t        rec_new;

  assign empty = (count == 2'd0);
  assign rec = mem[rd_ptr];
  assign do_pop = pop && !empty;
  assign out_space = (count != 2'd2) || do_pop;
  assign is_byte = (tok.cls == CLS_BYTE);
  assign tok_take = tok_valid && (is_byte || out_space);
  assign rec_wr = tok_take && !is_byte;

  assign sc = {{24{tok.ch[7]}}, tok.ch};
  // h * 65599 + c
  assign hash_next = sc + (run_hash << 6) + (run_hash << 16) - run_hash;
  assign pos_inc = inc_sat16(position, MaxPos);
  assign one_byte = (bytes_in_level == 2'd1);

  always_comb begin
    plus_next = plus_levels;
    hash_levels_next = hash_levels;
    rec_new.level_kind = KIND_PLAIN;
    if (one_byte && first_byte_of_level == CH_PLUS) begin
      rec_new.level_kind = KIND_PLUS;
      plus_next = inc_sat16(plus_levels, Sat16);
    end else if (one_byte && first_byte_of_level == CH_HASH) begin
      rec_new.level_kind = KIND_HASH;
      hash_levels_next = inc_sat16(hash_levels, Sat16);
    end
    levels_next = inc_sat16(levels_seen, Sat16);
    system_next = system_flag;
    if (levels_seen == 16'd0) begin
      system_next = (bytes_in_level != 2'd0) && (first_byte_of_level == CH_DOLLAR);
    end
    rec_new.level_index = levels_seen;
    rec_new.level_start = start_of_level;
    rec_new.level_hash = run_hash;
    rec_new.last = (tok.cls == CLS_END);
    rec_new.level_count = levels_next;
    rec_new.wildcard_count = plus_next;
    rec_new.multicard_count = hash_levels_next;
    rec_new.system_topic = system_next;
    rec_new.too_deep = (tok.cls == CLS_END) && (levels_next > max_depth);
    rec_new.topic_length = position;
  end

  always_ff @(posedge clk) begin
    if (rec_wr) begin
      mem[wr_ptr] <= rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (rec_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, rec_wr} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_hash            <= '0;
      position            <= '0;
      start_of_level      <= '0;
      first_byte_of_level <= '0;
      bytes_in_level      <= '0;
      levels_seen         <= '0;
      plus_levels         <= '0;
      hash_levels         <= '0;
      system_flag         <= 1'b0;
    end else if (tok_take) begin
      if (is_byte) begin
        run_hash <= hash_next;
        if (bytes_in_level == 2'd0) begin
          first_byte_of_level <= tok.ch;
        end
        if (bytes_in_level != 2'd2) begin
          bytes_in_level <= bytes_in_level + 2'd1;
        end
        position <= pos_inc;
      end else if (tok.cls == CLS_END) begin
        // drop all topic state
        run_hash            <= '0;
        position            <= '0;
        start_of_level      <= '0;
        first_byte_of_level <= '0;
        bytes_in_level      <= '0;
        levels_seen         <= '0;
        plus_levels         <= '0;
        hash_levels         <= '0;
        system_flag         <= 1'b0;
      end else begin
        position            <= pos_inc;
        start_of_level      <= pos_inc;
        run_hash            <= '0;
        first_byte_of_level <= '0;
        bytes_in_level      <= '0;
        levels_seen         <= levels_next;
        plus_levels         <= plus_next;
        hash_levels         <= hash_levels_next;
        system_flag         <= system_next;
      end
    end
  end

endmodule

[hw/rtl/topic_level_analyser.sv]
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+---------------------------------------
// config    | in/out    | psel/penable/pready | paddr, pwdata, prdata (max_depth)
// byte in   | in        | push / full        | ch
// record    | out       | empty / pop        | level_index .. topic_length
//
// One byte per cycle while full is low: bytes pass the input queue to the level
// state unit, which updates the hash and counters for one byte each cycle unless
// a '/' or end finds the record queue full, and writes a record there on each
// '/' or end. Reset (rst, synchronous) empties both queues and clears the topic
// state; max_depth returns to 32. A stalled record output fills the two-entry
// record queue, then the two-entry byte queue, and only then raises full.
module topic_level_analyser #(
  parameter int MAX_TOPIC_LENGTH = tla_pkg::TLA_MAX_TOPIC_LENGTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  input  logic [7:0]  ch,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] level_index,
  output logic [15:0] level_start,
  output logic [31:0] level_hash,
  output logic [1:0]  level_kind,
  output logic        last,
  output logic [15:0] level_count,
  output logic [15:0] wildcard_count,
  output logic [15:0] multicard_count,
  output logic        system_topic,
  output logic        too_deep,
  output logic [15:0] topic_length
);
  import tla_pkg::*;

  logic [15:0] max_depth;
  logic        tok_valid;
  tok_t        tok;
  logic        tok_take;
  rec_t        rec;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_DEPTH) ? {16'd0, max_depth} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth <= TLA_MAX_DEPTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_DEPTH) begin
      max_depth <= pwdata[15:0];
    end
  end

  tla_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .ch        (ch),
    .full      (full),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_take  (tok_take)
  );

  tla_back #(
    .MAX_TOPIC_LENGTH (MAX_TOPIC_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_depth (max_depth),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_take  (tok_take),
    .empty     (empty),
    .pop       (pop),
    .rec       (rec)
  );

  assign level_index     = rec.level_index;
  assign level_start     = rec.level_start;
  assign level_hash      = rec.level_hash;
  assign level_kind      = rec.level_kind;
  assign last            = rec.last;
  assign level_count     = rec.level_count;
  assign wildcard_count  = rec.wildcard_count;
  assign multicard_count = rec.multicard_count;
  assign system_topic    = rec.system_topic;
  assign too_deep        = rec.too_deep;
  assign topic_length    = rec.topic_length;

endmodule

[hw/rtl/tla_checker.sv]
module tla_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] level_index,
  input logic [31:0] level_hash,
  input logic        last,
  input logic [15:0] level_count,
  input logic        too_deep
);

  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(level_hash) && $stable(last)))
    else $error("record changed while stalled");

  a_count_follows_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && level_index != 16'hFFFF) |-> (level_count == level_index + 16'd1))
    else $error("level count does not follow level index");

  a_deep_only_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last) |-> !too_deep)
    else $error("too_deep set on a record that is not last");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2]
      |-> (prdata[15:0] == $past(pwdata[15:0])))
    else $error("max_depth readback mismatch");

endmodule

bind topic_level_analyser tla_checker u_tla_checker (
  .clk         (clk),
  .rst         (rst),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .level_index (level_index),
  .level_hash  (level_hash),
  .last        (last),
  .level_count (level_count),
  .too_deep    (too_deep)
);

[bench/tb_topic_level_analyser.sv]
`timescale 1ns / 100ps

module tb_topic_level_analyser;
  import tla_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  class level_record_board;
    rec_t        records_due[$];
    logic [15:0] depth_limit;
    logic [31:0] hash_acc;
    logic [15:0] byte_pos;
    logic [15:0] lvl_start;
    logic [7:0]  lvl_first;
    logic [1:0]  lvl_bytes;
    logic [15:0] lvl_count;
    logic [15:0] plus_count;
    logic [15:0] multi_count;
    logic        sys_flag;
    int          errors;
    int          records_checked;
    int          topics_done;

    function new();
      depth_limit = TLA_MAX_DEPTH_RESET;
      clear_topic();
      errors = 0;
      records_checked = 0;
      topics_done = 0;
    endfunction

    function void clear_topic();
      hash_acc = '0;
      byte_pos = '0;
      lvl_start = '0;
      lvl_first = '0;
      lvl_bytes = '0;
      lvl_count = '0;
      plus_count = '0;
      multi_count = '0;
      sys_flag = 1'b0;
    endfunction

    function void set_depth(logic [15:0] v);
      depth_limit = v;
    endfunction

    function int due();
      return records_due.size();
    endfunction

    // Advance the topic state by one accepted byte; queue a record on '/' or end.
    function void take_byte(logic [7:0] c);
      rec_t        r;
      logic [31:0] sc;
      if (c != CH_END && c != CH_SLASH) begin
        sc = {{24{c[7]}}, c};
        hash_acc = sc + (hash_acc << 6) + (hash_acc << 16) - hash_acc;
        if (lvl_bytes == 2'd0) lvl_first = c;
        if (lvl_bytes != 2'd2) lvl_bytes = lvl_bytes + 2'd1;
        if (byte_pos < TLA_MAX_TOPIC_LENGTH) byte_pos = byte_pos + 16'd1;
        return;
      end
      r.level_kind = KIND_PLAIN;
      if (lvl_bytes == 2'd1) begin
        if (lvl_first == CH_PLUS) begin
          r.level_kind = KIND_PLUS;
          if (plus_count != 16'hFFFF) plus_count = plus_count + 16'd1;
        end else if (lvl_first == CH_HASH) begin
          r.level_kind = KIND_HASH;
          if (multi_count != 16'hFFFF) multi_count = multi_count + 16'd1;
        end
      end
      r.level_index = lvl_count;
      if (lvl_count == 16'd0) sys_flag = (lvl_bytes != 2'd0) && (lvl_first == CH_DOLLAR);
      if (lvl_count != 16'hFFFF) lvl_count = lvl_count + 16'd1;
      r.level_start = lvl_start;
      r.level_hash = hash_acc;
      r.last = (c == CH_END);
      r.level_count = lvl_count;
      r.wildcard_count = plus_count;
      r.multicard_count = multi_count;
      r.system_topic = sys_flag;
      r.too_deep = r.last && (lvl_count > depth_limit);
      r.topic_length = byte_pos;
      records_due.push_back(r);
      if (r.last) begin
        clear_topic();
      end else begin
        if (byte_pos < TLA_MAX_TOPIC_LENGTH) byte_pos = byte_pos + 16'd1;
        lvl_start = byte_pos;
        hash_acc = '0;
        lvl_first = '0;
        lvl_bytes = '0;
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("mismatch: %s", what);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                         records_checked, name, got, want));
    endtask

    task match_record(rec_t got);
      rec_t want;
      if (records_due.size() == 0) begin
        report($sformatf("record %0d arrived with none expected", records_checked));
        records_checked++;
        return;
      end
      want = records_due.pop_front();
      check_field("level_index", 32'(got.level_index), 32'(want.level_index));
      check_field("level_start", 32'(got.level_start), 32'(want.level_start));
      check_field("level_hash", got.level_hash, want.level_hash);
      check_field("level_kind", 32'(got.level_kind), 32'(want.level_kind));
      check_field("last", 32'(got.last), 32'(want.last));
      check_field("level_count", 32'(got.level_count), 32'(want.level_count));
      check_field("wildcard_count", 32'(got.wildcard_count), 32'(want.wildcard_count));
      check_field("multicard_count", 32'(got.multicard_count),
                  32'(want.multicard_count));
      check_field("system_topic", 32'(got.system_topic), 32'(want.system_topic));
      check_field("too_deep", 32'(got.too_deep), 32'(want.too_deep));
      check_field("topic_length", 32'(got.topic_length), 32'(want.topic_length));
      if (want.last) topics_done++;
      records_checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic [7:0]  ch = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] level_index;
  logic [15:0] level_start;
  logic [31:0] level_hash;
  logic [1:0]  level_kind;
  logic        last;
  logic [15:0] level_count;
  logic [15:0] wildcard_count;
  logic [15:0] multicard_count;
  logic        system_topic;
  logic        too_deep;
  logic [15:0] topic_length;

  rec_t seen_rec;
  assign seen_rec = {level_index, level_start, level_hash, level_kind, last, level_count,
                     wildcard_count, multicard_count, system_topic, too_deep, topic_length};

  level_record_board board = new();

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   bytes_sent = 0;
  int   full_cycles = 0;
  int   depth_writes = 0;
  int   quiet = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;

  topic_level_analyser dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .ch(ch), .full(full),
    .empty(empty), .pop(pop),
    .level_index(level_index), .level_start(level_start), .level_hash(level_hash),
    .level_kind(level_kind), .last(last), .level_count(level_count),
    .wildcard_count(wildcard_count), .multicard_count(multicard_count),
    .system_topic(system_topic), .too_deep(too_deep), .topic_length(topic_length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off started by a one-cycle request.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_req) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      pop <= !hold_req && hold_left == 0 && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) board.take_byte(ch);
      if (push && full) full_cycles++;
      if (pop && !empty) board.match_record(seen_rec);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // Drop push and hold until every record is in, then let the pipeline settle.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (board.due() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_depth(input logic [15:0] depth);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MAX_DEPTH, 2'b00};
    pwdata <= {16'($urandom), depth};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_depth(depth);
    depth_writes++;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(7))
      0: v = CH_PLUS;
      1: v = CH_HASH;
      2: v = CH_DOLLAR;
      default: begin
        v = 8'($urandom_range(1, 255));
        if (v == CH_SLASH) v = 8'h80;
      end
    endcase
    return v;
  endfunction

  task automatic send_topic(input int n_levels);
    int len;
    for (int i = 0; i < n_levels; i++) begin
      if (i != 0) send_byte(CH_SLASH);
      case ($urandom_range(9))
        0: send_byte(CH_PLUS);
        1: send_byte(CH_HASH);
        2: ;  // empty level
        3: begin
          send_byte(CH_DOLLAR);
          send_byte(pick_byte());
        end
        default: begin
          len = $urandom_range(1, 6);
          repeat (len) send_byte(pick_byte());
        end
      endcase
    end
    send_byte(CH_END);
  endtask

  task automatic run_random(input int quota);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < quota) begin
      if ($urandom_range(9) == 0) begin
        // raw noise, closed by a terminator so the phase ends on a topic boundary
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
        send_byte(CH_END);
      end else if ($urandom_range(7) == 0) begin
        send_topic($urandom_range(1, 20));
      end else begin
        send_topic($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    logic [7:0] seq[$];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // system prefix and both wildcards; empty first level with high bytes and "+#";
    // empty topic; trailing empty level
    seq = '{CH_DOLLAR, 8'h61, CH_SLASH, CH_PLUS, CH_SLASH, CH_HASH, CH_END,
            CH_SLASH, 8'h80, 8'hFF, CH_SLASH, CH_PLUS, CH_HASH, CH_END,
            CH_END,
            8'h7F, 8'h01, CH_SLASH, CH_END};
    send_bytes(seq);
    wait_drained();
    write_depth(16'd0);
    seq = '{8'h61, CH_END};
    send_bytes(seq);
    wait_drained();
    write_depth(16'd1);
    seq = '{8'h61, CH_SLASH, 8'h62, CH_END, CH_PLUS, CH_END};
    send_bytes(seq);
    wait_drained();

    // no idling, with a long receiver hold-off to back up the input
    write_depth(16'd3);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_random(300);
    wait_drained();

    write_depth(16'd1);
    send_idle_pct = 62;
    run_random(150);
    wait_drained();
    run_random(150);
    wait_drained();

    write_depth(16'hFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 62;
    run_random(300);
    wait_drained();

    write_depth(16'($urandom_range(2, 10)));
    send_idle_pct = 14;
    recv_stall_pct = 14;
    run_random(300);
    wait_drained();

    $display("Run: %0d bytes, %0d level records, %0d topics, input held by full %0d cycles.",
             bytes_sent, board.records_checked, board.topics_done, full_cycles);
    $display("max_depth written %0d times (0, 1, 3, 65535, random) between drained phases.",
             depth_writes);
    if (board.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
